// File: sv/tkt_pkg.sv
// Shared types, byte codes and the key table of the terminal key tokenizer.
package tkt_pkg;

    localparam int DEF_BUFFER_DEPTH = 16;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 5;
    localparam int MAX_RESULTS      = 16;
    localparam int RES_W            = 5;

    localparam logic [LEN_W-1:0] MAX_LEN = 5'd31;

    typedef logic [BYTE_W-1:0]       t_byte;
    typedef logic [3:0][BYTE_W-1:0]  t_head_bytes;

    // escape sequence bytes
    localparam t_byte CH_ESC       = 8'h1B;
    localparam t_byte CH_LBRACKET  = 8'h5B;
    localparam t_byte CH_SS3       = 8'h4F;
    localparam t_byte CSI_PARAM_LO = 8'h30;
    localparam t_byte CSI_PARAM_HI = 8'h3F;

    // key bytes
    localparam t_byte CH_A     = 8'h41;
    localparam t_byte CH_B     = 8'h42;
    localparam t_byte CH_5     = 8'h35;
    localparam t_byte CH_6     = 8'h36;
    localparam t_byte CH_TILDE = 8'h7E;
    localparam t_byte CH_K     = 8'h6B;
    localparam t_byte CH_J     = 8'h6A;
    localparam t_byte CH_DLE   = 8'h10;
    localparam t_byte CH_SO    = 8'h0E;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_PLUS  = 8'h2B;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_M     = 8'h6D;
    localparam t_byte CH_Q     = 8'h71;

    // UTF-8 ranges
    localparam t_byte U8_ASCII_LO = 8'h00;
    localparam t_byte U8_ASCII_HI = 8'h7F;
    localparam t_byte U8_LEAD2_LO = 8'hC2;
    localparam t_byte U8_LEAD2_HI = 8'hDF;
    localparam t_byte U8_LEAD3_LO = 8'hE0;
    localparam t_byte U8_LEAD3_HI = 8'hEF;
    localparam t_byte U8_LEAD_HI  = 8'hF4;
    localparam t_byte U8_CONT_LO  = 8'h80;
    localparam t_byte U8_CONT_HI  = 8'hBF;
    localparam t_byte U8_LEAD_E0  = 8'hE0;
    localparam t_byte U8_LEAD_ED  = 8'hED;
    localparam t_byte U8_LEAD_F0  = 8'hF0;
    localparam t_byte U8_LEAD_F4  = 8'hF4;
    localparam t_byte U8_E0_LO    = 8'hA0;
    localparam t_byte U8_ED_HI    = 8'h9F;
    localparam t_byte U8_F0_LO    = 8'h90;
    localparam t_byte U8_F4_HI    = 8'h8F;

    typedef enum logic [2:0] {
        KEY_NONE,
        KEY_UP,
        KEY_DOWN,
        KEY_SELECT,
        KEY_VOL_UP,
        KEY_VOL_DOWN,
        KEY_MUTE,
        KEY_QUIT
    } t_key;

    typedef enum logic {
        CMD_BYTE,
        CMD_TIMEOUT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_byte     data;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_SC_HEAD,
        ST_SC_CSI,
        ST_SC_SS3,
        ST_SC_UTF,
        ST_EMIT,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        SC_MORE,
        SC_DONE,
        SC_PART
    } t_scan_act;

    // exact match of a token against the fixed key table; len 0 means no match
    function automatic t_key key_lookup(input logic [2:0] len, input t_head_bytes b);
        t_key k;
        k = KEY_NONE;
        case (len)
            3'd1: begin
                case (b[0])
                    CH_K, CH_DLE:   k = KEY_UP;
                    CH_J, CH_SO:    k = KEY_DOWN;
                    CH_CR:          k = KEY_SELECT;
                    CH_PLUS:        k = KEY_VOL_UP;
                    CH_MINUS:       k = KEY_VOL_DOWN;
                    CH_M:           k = KEY_MUTE;
                    CH_Q, CH_ESC:   k = KEY_QUIT;
                    default:        k = KEY_NONE;
                endcase
            end
            3'd3: begin
                if (b[0] == CH_ESC && b[1] == CH_LBRACKET) begin
                    if (b[2] == CH_A) begin
                        k = KEY_UP;
                    end else if (b[2] == CH_B) begin
                        k = KEY_DOWN;
                    end
                end
            end
            3'd4: begin
                if (b[0] == CH_ESC && b[1] == CH_LBRACKET && b[3] == CH_TILDE) begin
                    if (b[2] == CH_5) begin
                        k = KEY_VOL_UP;
                    end else if (b[2] == CH_6) begin
                        k = KEY_VOL_DOWN;
                    end
                end
            end
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

// File: sv/tkt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkt_ram import tkt_pkg::*; #(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tkt_front.sv
// Input side: takes stream words, tags them as byte or timeout, two-entry command queue.
module tkt_front import tkt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  logic [BYTE_W-1:0] i_tdata,
    input  logic              i_tuser,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd
);

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_fill, n_fill;
    t_cmd       cmd_in;
    logic       push, pop;

    always_comb begin
        cmd_in.kind = i_tuser ? CMD_TIMEOUT : CMD_BYTE;
        cmd_in.data = i_tdata;
    end

    assign o_tready    = (r_fill != 2'(QD));
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_tvalid && o_tready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp   = push ? ~r_wp : r_wp;
        n_rp   = pop  ? ~r_rp : r_rp;
        n_fill = r_fill + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// File: sv/tkt_back.sv
// Back end: pending byte buffer, byte-serial token scanner and result output register.
module tkt_back import tkt_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [BYTE_W-1:0] o_tdata,
    output logic              o_tlast
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [CW-1:0] FULL = CW'(BUFFER_DEPTH);

    // circular buffer index add, off <= BUFFER_DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(BUFFER_DEPTH)) begin
            sum = sum - SW'(BUFFER_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_idx, n_idx;
    logic [1:0]        r_esc, n_esc;
    logic [1:0]        r_rem, n_rem;
    t_byte             r_lo, n_lo;
    t_byte             r_hi, n_hi;
    t_head_bytes       r_b, n_b;
    logic [CW-1:0]     r_len, n_len;
    logic              r_force, n_force;
    logic              r_pend, n_pend;
    t_byte             r_byte, n_byte;
    logic [RES_W-1:0]  r_produced, n_produced;
    logic              r_hold_v, n_hold_v;
    logic [LEN_W-1:0]  r_hold_len, n_hold_len;
    t_key              r_hold_key, n_hold_key;
    logic              r_out_v, n_out_v;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    t_key              r_out_key, n_out_key;
    logic              r_out_last, n_out_last;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    t_byte             rd_data;

    t_scan_act         sc_act;
    logic [CW-1:0]     sc_len;
    t_state            sc_goto;
    logic [1:0]        sc_esc, sc_rem;
    t_byte             sc_lo, sc_hi;
    logic              at_end;
    logic [CW-1:0]     idx_p1, e_len, e_p1;
    t_state            post_state;
    logic              out_free, emit_go, budget_out;
    logic [LW-1:0]     len_ext;
    logic [LEN_W-1:0]  tok_len;
    t_key              tok_key;

    tkt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_byte),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    assign out_free   = !r_out_v || i_tready;
    assign emit_go    = !r_hold_v || out_free;
    assign budget_out = (r_produced == RES_W'(MAX_RESULTS));
    assign post_state = r_pend ? ST_WRITE : ST_FINISH;
    assign at_end     = (r_idx == r_cnt);
    assign idx_p1     = r_idx + CW'(1);
    assign e_len      = CW'(r_esc);
    assign e_p1       = CW'(r_esc) + CW'(1);

    // token length and key of the token at the head
    always_comb begin
        len_ext = LW'(r_len);
        tok_len = (len_ext > LW'(MAX_LEN)) ? MAX_LEN : len_ext[LEN_W-1:0];
        tok_key = key_lookup((len_ext <= LW'(4)) ? len_ext[2:0] : 3'd0, r_b);
    end

    // one scanned byte per cycle: rd_data is the byte at index r_idx
    always_comb begin
        sc_act  = SC_MORE;
        sc_len  = idx_p1;
        sc_goto = r_state;
        sc_esc  = r_esc;
        sc_rem  = r_rem;
        sc_lo   = r_lo;
        sc_hi   = r_hi;
        case (r_state)
            ST_SC_HEAD: begin
                if (at_end) begin
                    sc_act = SC_PART;
                    sc_len = e_len;
                end else if (rd_data == CH_ESC && r_esc != 2'd2) begin
                    sc_esc = r_esc + 2'd1;
                end else if (r_esc != 2'd0 && rd_data == CH_LBRACKET) begin
                    sc_goto = ST_SC_CSI;
                end else if (r_esc != 2'd0 && rd_data == CH_SS3) begin
                    sc_goto = ST_SC_SS3;
                end else if (r_esc == 2'd2) begin
                    // double escape before an unknown byte stands alone
                    sc_act = SC_DONE;
                    sc_len = CW'(2);
                end else if (rd_data inside {[U8_ASCII_LO:U8_ASCII_HI]}) begin
                    sc_act = SC_DONE;
                    sc_len = e_p1;
                end else if (!(rd_data inside {[U8_LEAD2_LO:U8_LEAD_HI]})) begin
                    sc_act = SC_DONE;
                    sc_len = e_p1;
                end else begin
                    sc_goto = ST_SC_UTF;
                    if (rd_data inside {[U8_LEAD2_LO:U8_LEAD2_HI]}) begin
                        sc_rem = 2'd1;
                    end else if (rd_data inside {[U8_LEAD3_LO:U8_LEAD3_HI]}) begin
                        sc_rem = 2'd2;
                    end else begin
                        sc_rem = 2'd3;
                    end
                    sc_lo = (rd_data == U8_LEAD_E0) ? U8_E0_LO :
                            (rd_data == U8_LEAD_F0) ? U8_F0_LO : U8_CONT_LO;
                    sc_hi = (rd_data == U8_LEAD_ED) ? U8_ED_HI :
                            (rd_data == U8_LEAD_F4) ? U8_F4_HI : U8_CONT_HI;
                end
            end
            ST_SC_CSI: begin
                if (at_end) begin
                    sc_act = SC_PART;
                    sc_len = e_len;
                end else if (!(rd_data inside {[CSI_PARAM_LO:CSI_PARAM_HI]})) begin
                    sc_act = SC_DONE;
                end
            end
            ST_SC_SS3: begin
                if (at_end) begin
                    sc_act = SC_PART;
                    sc_len = e_len;
                end else begin
                    sc_act = SC_DONE;
                end
            end
            ST_SC_UTF: begin
                if (at_end) begin
                    sc_act = SC_PART;
                    sc_len = e_p1;
                end else if (rd_data < r_lo || rd_data > r_hi) begin
                    sc_act = SC_DONE;
                    sc_len = e_p1;
                end else if (r_rem == 2'd1) begin
                    sc_act = SC_DONE;
                end else begin
                    sc_rem = r_rem - 2'd1;
                    sc_lo  = U8_CONT_LO;
                    sc_hi  = U8_CONT_HI;
                end
            end
            default: sc_act = SC_MORE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.kind == CMD_BYTE && r_cnt != FULL) ? ST_WRITE : ST_LOAD;
                end
            end
            ST_WRITE: n_state = ST_LOAD;
            ST_LOAD: begin
                n_state = (r_cnt == '0 || budget_out) ? post_state : ST_SC_HEAD;
            end
            ST_SC_HEAD, ST_SC_CSI, ST_SC_SS3, ST_SC_UTF: begin
                case (sc_act)
                    SC_MORE: n_state = sc_goto;
                    SC_DONE: n_state = ST_EMIT;
                    SC_PART: n_state = r_force ? ST_EMIT : post_state;
                    default: n_state = post_state;
                endcase
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_state = ST_LOAD;
                end
            end
            ST_FINISH: begin
                if (!r_hold_v || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_esc      = r_esc;
        n_rem      = r_rem;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_b        = r_b;
        n_len      = r_len;
        n_force    = r_force;
        n_pend     = r_pend;
        n_byte     = r_byte;
        n_produced = r_produced;
        n_hold_v   = r_hold_v;
        n_hold_len = r_hold_len;
        n_hold_key = r_hold_key;
        n_out_v    = r_out_v && !i_tready;
        n_out_len  = r_out_len;
        n_out_key  = r_out_key;
        n_out_last = r_out_last;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = wrap_add(r_head, r_cnt);
        ram_raddr   = r_head;
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_byte     = i_cmd.data;
                    n_produced = '0;
                    // a full buffer is resolved as on a timeout before the byte goes in
                    n_force    = (i_cmd.kind == CMD_TIMEOUT) || (r_cnt == FULL);
                    n_pend     = (i_cmd.kind == CMD_BYTE);
                end
            end
            ST_WRITE: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + CW'(1);
                n_pend = 1'b0;
            end
            ST_LOAD: begin
                ram_raddr = r_head;
                n_idx     = '0;
                n_esc     = 2'd0;
            end
            ST_SC_HEAD, ST_SC_CSI, ST_SC_SS3, ST_SC_UTF: begin
                ram_raddr = (idx_p1 < r_cnt) ? wrap_add(r_head, idx_p1) : r_head;
                if (!at_end && r_idx < CW'(4)) begin
                    n_b[r_idx[1:0]] = rd_data;
                end
                n_idx = idx_p1;
                n_len = sc_len;
                n_esc = sc_esc;
                n_rem = sc_rem;
                n_lo  = sc_lo;
                n_hi  = sc_hi;
            end
            ST_EMIT: begin
                if (emit_go) begin
                    if (r_hold_v) begin
                        n_out_v    = 1'b1;
                        n_out_len  = r_hold_len;
                        n_out_key  = r_hold_key;
                        n_out_last = 1'b0;
                    end
                    n_hold_v   = 1'b1;
                    n_hold_len = tok_len;
                    n_hold_key = tok_key;
                    n_head     = wrap_add(r_head, r_len);
                    n_cnt      = r_cnt - r_len;
                    n_produced = r_produced + RES_W'(1);
                    n_force    = 1'b0;
                end
            end
            ST_FINISH: begin
                if (r_hold_v && out_free) begin
                    n_out_v    = 1'b1;
                    n_out_len  = r_hold_len;
                    n_out_key  = r_hold_key;
                    n_out_last = 1'b1;
                    n_hold_v   = 1'b0;
                end
            end
            default: n_out_v = r_out_v && !i_tready;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_cnt      <= '0;
            r_force    <= 1'b0;
            r_pend     <= 1'b0;
            r_produced <= '0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_cnt      <= n_cnt;
            r_force    <= n_force;
            r_pend     <= n_pend;
            r_produced <= n_produced;
            r_hold_v   <= n_hold_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_esc      <= n_esc;
        r_rem      <= n_rem;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_b        <= n_b;
        r_len      <= n_len;
        r_byte     <= n_byte;
        r_hold_len <= n_hold_len;
        r_hold_key <= n_hold_key;
        r_out_len  <= n_out_len;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
    end

    assign o_tvalid = r_out_v;
    assign o_tdata  = {r_out_key, r_out_len};
    assign o_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_cnt_grows_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != ST_WRITE) |=> (r_cnt <= $past(r_cnt)))
        else $error("buffer count grew outside a write");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (r_cnt < FULL))
        else $error("byte written into a full buffer");

    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_len != '0 && r_len <= r_cnt))
        else $error("token length outside the pending bytes");

    a_emit_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_produced < RES_W'(MAX_RESULTS)))
        else $error("more tokens than the per-word budget");

    a_cmd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_ready && i_cmd_valid) |-> (!r_hold_v && !r_pend))
        else $error("new word taken with a token or byte still held");
`endif

endmodule

// File: sv/terminal_key_tokenizer_top.sv
// Terminal key tokenizer top level: command queue, scanner back end, pending-byte RAM.
// Sequence: a byte word is written into the buffer, then the buffer head is loaded and
//   rescanned byte by byte; each token found adds an emit, then a reload of the buffer head.
// Throughput: sequential, the back end takes no new word until it is done with the last;
//   the scan is paced by the one-byte-per-cycle RAM read port.
// Reset: synchronous, active low; clears queue, buffer count and scanner, not the bytes.
module terminal_key_tokenizer_top import tkt_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input words
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] byte_value
    input  logic              s_axis_tuser,   // [0] action: 0 byte, 1 timeout
    // token words
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [4:0] token_length, [7:5] key_action
    output logic              m_axis_tlast    // last token of the input word
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // Front end: accepts words while the back end is busy, up to two queued.
    tkt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Back end: appends bytes, rescans the buffer head byte by byte, forces out
    // partial tokens on timeout or overflow, and holds back each token one slot
    // so the final one of a word can carry tlast. Output register decouples
    // the token stream from downstream stalls.
    tkt_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule
